// ===== rtl/rib_pkg.sv =====
package rib_pkg;

  localparam int CFG_W     = 12;
  localparam int CIDX_W    = 3;
  localparam int AREA_W    = 12;
  localparam int DIM_REG_W = 11;
  localparam int ALIGN_W   = 4;
  localparam int DEG_W     = 9;
  localparam int CH_W      = 8;
  localparam int COLOR_W   = 24;
  localparam int SCR_W     = 13;
  localparam int COORD_W   = 16;
  localparam int CLIP_W    = COORD_W + 1;
  localparam int AOFF_W    = 14;
  localparam int QTAB_N    = 91;
  localparam int QIDX_W    = 7;

  localparam logic [DEG_W:0] DEG_FULL    = 10'd360;
  localparam logic [DEG_W:0] DEG_3Q      = 10'd270;
  localparam logic [DEG_W:0] DEG_HALF    = 10'd180;
  localparam logic [DEG_W:0] DEG_QUARTER = 10'd90;
  localparam logic [ALIGN_W-1:0] ALIGN_MAX = 4'd8;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int SERIES_TERMS = 40;

  typedef enum logic [CIDX_W-1:0] {
    REG_AREA_X   = 3'd0,
    REG_AREA_Y   = 3'd1,
    REG_AREA_W   = 3'd2,
    REG_AREA_H   = 3'd3,
    REG_IMG_W    = 3'd4,
    REG_IMG_H    = 3'd5,
    REG_ALIGN    = 3'd6,
    REG_ROTATION = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ALIGN_START  = 2'd0,
    ALIGN_CENTER = 2'd1,
    ALIGN_END    = 2'd2
  } align_e;

  typedef struct packed {
    logic [AREA_W-1:0]    area_x;
    logic [AREA_W-1:0]    area_y;
    logic [AREA_W-1:0]    area_width;
    logic [AREA_W-1:0]    area_height;
    logic [DIM_REG_W-1:0] image_width;
    logic [DIM_REG_W-1:0] image_height;
    logic [ALIGN_W-1:0]   align_mode;
    logic [DEG_W-1:0]     rotation_degrees;
  } cfg_t;

  typedef struct packed {
    align_e h;
    align_e v;
  } align_sel_t;

  typedef struct packed {
    logic [QIDX_W-1:0] idx;
    logic              neg;
  } trig_sel_t;

  // codes above 8 fall back to centre/centre
  function automatic align_sel_t align_decode(input logic [ALIGN_W-1:0] mode);
    align_sel_t s;
    case (mode)
      4'd0:    s = '{h: ALIGN_START,  v: ALIGN_START};
      4'd1:    s = '{h: ALIGN_CENTER, v: ALIGN_START};
      4'd2:    s = '{h: ALIGN_END,    v: ALIGN_START};
      4'd3:    s = '{h: ALIGN_START,  v: ALIGN_CENTER};
      4'd4:    s = '{h: ALIGN_CENTER, v: ALIGN_CENTER};
      4'd5:    s = '{h: ALIGN_END,    v: ALIGN_CENTER};
      4'd6:    s = '{h: ALIGN_START,  v: ALIGN_END};
      4'd7:    s = '{h: ALIGN_CENTER, v: ALIGN_END};
      4'd8:    s = '{h: ALIGN_END,    v: ALIGN_END};
      default: s = '{h: ALIGN_CENTER, v: ALIGN_CENTER};
    endcase
    return s;
  endfunction

  // halving truncates toward zero
  function automatic logic signed [AOFF_W-1:0] align_off(input align_e sel,
                                                         input logic signed [AOFF_W-1:0] diff);
    logic signed [AOFF_W-1:0] adj;
    logic signed [AOFF_W-1:0] res;
    adj = diff + AOFF_W'(diff[AOFF_W-1]);
    case (sel)
      ALIGN_CENTER: res = adj >>> 1;
      ALIGN_END:    res = diff;
      default:      res = '0;
    endcase
    return res;
  endfunction

  // d in 0..359
  function automatic trig_sel_t trig_select(input logic [DEG_W:0] d);
    trig_sel_t s;
    if (d <= DEG_QUARTER) begin
      s.idx = QIDX_W'(d);
      s.neg = 1'b0;
    end else if (d <= DEG_HALF) begin
      s.idx = QIDX_W'(DEG_HALF - d);
      s.neg = 1'b0;
    end else if (d <= DEG_3Q) begin
      s.idx = QIDX_W'(d - DEG_HALF);
      s.neg = 1'b1;
    end else begin
      s.idx = QIDX_W'(DEG_FULL - d);
      s.neg = 1'b1;
    end
    return s;
  endfunction

  // divide by 2n(2n+1)
  function automatic longint unsigned series_div(input longint unsigned t, input int n);
    longint unsigned r;
    case (n)
      1:       r = t / 64'd6;
      2:       r = t / 64'd20;
      3:       r = t / 64'd42;
      4:       r = t / 64'd72;
      5:       r = t / 64'd110;
      6:       r = t / 64'd156;
      7:       r = t / 64'd210;
      8:       r = t / 64'd272;
      9:       r = t / 64'd342;
      10:      r = t / 64'd420;
      11:      r = t / 64'd506;
      12:      r = t / 64'd600;
      13:      r = t / 64'd702;
      14:      r = t / 64'd812;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

  // quarter-wave sine in Q1.f, evaluated at elaboration
  function automatic longint unsigned qsin_calc(input int k, input int f);
    longint unsigned one;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    one  = 64'd1 << f;
    x    = (64'(k) * PI_Q30) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = 0;
    for (int n = 1; n < SERIES_TERMS; n++) begin
      if (term != 64'd0) begin
        if (n[0]) begin
          sum = sum + longint'(term);
        end else begin
          sum = sum - longint'(term);
        end
        term = series_div((term * x2) >> 30, n);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (((longint'(sum) * 2) >> (30 - f)) + 64'd1) >> 1;
    if (v > one) begin
      v = one;
    end
    if (k == 0) begin
      v = 64'd0;
    end else if (k == 90) begin
      v = one;
    end
    return v;
  endfunction

endpackage

// ===== rtl/rib_front.sv =====
module rib_front import rib_pkg::*; #(
  parameter int  MAX_IMAGE_DIM  = 1024,
  parameter int  TRIG_FRAC_BITS = 16,
  parameter type item_t         = logic
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [CH_W-1:0] red_i,
  input  logic [CH_W-1:0] green_i,
  input  logic [CH_W-1:0] blue_i,
  output logic            item_valid_o,
  input  logic            item_ready_i,
  output item_t           item_o
);

  localparam int CW   = $clog2(MAX_IMAGE_DIM);
  localparam int DW   = $clog2(MAX_IMAGE_DIM + 1);
  localparam int DX_W = DW + 1;
  localparam int QW   = TRIG_FRAC_BITS + 1;
  localparam int TW   = TRIG_FRAC_BITS + 2;

  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [DW-1:0] iw, ih;
  logic          last_col, last_row, accept;

  logic [QW-1:0] qtab [QTAB_N];

  for (genvar k = 0; k < QTAB_N; k++) begin : g_qtab
    assign qtab[k] = QW'(qsin_calc(k, TRIG_FRAC_BITS));
  end

  assign accept       = in_valid_i & item_ready_i;
  assign in_ready_o   = item_ready_i;
  assign item_valid_o = in_valid_i;

  always_comb begin
    if (cfg_i.image_width == '0) begin
      iw = DW'(1);
    end else if (int'(cfg_i.image_width) > MAX_IMAGE_DIM) begin
      iw = DW'(MAX_IMAGE_DIM);
    end else begin
      iw = DW'(cfg_i.image_width);
    end
    if (cfg_i.image_height == '0) begin
      ih = DW'(1);
    end else if (int'(cfg_i.image_height) > MAX_IMAGE_DIM) begin
      ih = DW'(MAX_IMAGE_DIM);
    end else begin
      ih = DW'(cfg_i.image_height);
    end
  end

  assign last_col = DW'(col_q) >= (iw - DW'(1));
  assign last_row = DW'(row_q) >= (ih - DW'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + CW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // placement
  align_sel_t               asel;
  logic signed [AOFF_W-1:0] diff_h, diff_v, off_h, off_v;
  logic signed [COORD_W-1:0] left, top;
  logic signed [DX_W-1:0]   dx, dy;

  always_comb begin
    asel   = align_decode(cfg_i.align_mode);
    diff_h = AOFF_W'(cfg_i.area_width) - AOFF_W'(iw);
    diff_v = AOFF_W'(cfg_i.area_height) - AOFF_W'(ih);
    off_h  = align_off(asel.h, diff_h);
    off_v  = align_off(asel.v, diff_v);
    left   = COORD_W'(cfg_i.area_x) + COORD_W'(off_h);
    top    = COORD_W'(cfg_i.area_y) + COORD_W'(off_v);
    dx     = DX_W'(col_q) - DX_W'(iw >> 1);
    dy     = DX_W'(row_q) - DX_W'(ih >> 1);
  end

  // angle
  logic [DEG_W:0]        deg, deg_c;
  trig_sel_t             s_sel, c_sel;
  logic [QW-1:0]         s_mag, c_mag;
  logic signed [TW-1:0]  sin_v, cos_v;

  always_comb begin
    deg = {1'b0, cfg_i.rotation_degrees};
    if (deg >= DEG_FULL) begin
      deg = deg - DEG_FULL;
    end
    deg_c = deg + DEG_QUARTER;
    if (deg_c >= DEG_FULL) begin
      deg_c = deg_c - DEG_FULL;
    end
    s_sel = trig_select(deg);
    c_sel = trig_select(deg_c);
    s_mag = qtab[s_sel.idx];
    c_mag = qtab[c_sel.idx];
    sin_v = s_sel.neg ? -TW'(s_mag) : TW'(s_mag);
    cos_v = c_sel.neg ? -TW'(c_mag) : TW'(c_mag);
  end

  always_comb begin
    item_o.dx    = dx;
    item_o.dy    = dy;
    item_o.sin_v = sin_v;
    item_o.cos_v = cos_v;
    item_o.cx    = left + COORD_W'(iw >> 1);
    item_o.cy    = top + COORD_W'(ih >> 1);
    item_o.color = {red_i, green_i, blue_i};
    item_o.eoi   = last_col & last_row;
  end

endmodule

// ===== rtl/rib_queue.sv =====
module rib_queue #(
  parameter int  DEPTH  = 2,
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output item_t out_item_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  item_t         mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;
  logic          push, pop;

  assign in_ready_o  = cnt_q != NW'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_valid_o & out_ready_i;
  assign out_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + NW'(push) - NW'(pop);
    end
  end

endmodule

// ===== rtl/rib_back.sv =====
module rib_back import rib_pkg::*; #(
  parameter int  MAX_IMAGE_DIM  = 1024,
  parameter int  TRIG_FRAC_BITS = 16,
  parameter type item_t         = logic
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  item_t              item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               draw_o,
  output logic [SCR_W-1:0]   screen_x_o,
  output logic [SCR_W-1:0]   screen_y_o,
  output logic [COLOR_W-1:0] color_o,
  output logic               end_of_image_o
);

  localparam int DW   = $clog2(MAX_IMAGE_DIM + 1);
  localparam int DX_W = DW + 1;
  localparam int TW   = TRIG_FRAC_BITS + 2;
  localparam int PW   = DX_W + TW;
  localparam int SW   = PW + 1;

  logic s1_v_q, s2_v_q, out_v_q;
  logic s1_en, s2_en, out_en;

  assign out_en       = !out_v_q | out_ready_i;
  assign s2_en        = !s2_v_q | out_en;
  assign s1_en        = !s1_v_q | s2_en;
  assign item_ready_o = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_q <= item_valid_i;
      end
      if (s2_en) begin
        s2_v_q <= s1_v_q;
      end
      if (out_en) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // stage 1: products
  logic signed [DX_W-1:0]    dx, dy;
  logic signed [TW-1:0]      sin_v, cos_v;
  logic signed [PW-1:0]      p_xc_q, p_ys_q, p_xs_q, p_yc_q;
  logic signed [COORD_W-1:0] cx1_q, cy1_q;
  logic [COLOR_W-1:0]        color1_q;
  logic                      eoi1_q;

  assign dx    = item_i.dx;
  assign dy    = item_i.dy;
  assign sin_v = item_i.sin_v;
  assign cos_v = item_i.cos_v;

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      p_xc_q   <= dx * cos_v;
      p_ys_q   <= dy * sin_v;
      p_xs_q   <= dx * sin_v;
      p_yc_q   <= dy * cos_v;
      cx1_q    <= item_i.cx;
      cy1_q    <= item_i.cy;
      color1_q <= item_i.color;
      eoi1_q   <= item_i.eoi;
    end
  end

  // stage 2: sums, truncate toward zero, re-centre
  logic signed [SW-1:0]      sum_x, sum_y, adj_x, adj_y, sh_x, sh_y;
  logic [SW-1:0]             bias_x, bias_y;
  logic signed [COORD_W-1:0] tx_q, ty_q;
  logic [COLOR_W-1:0]        color2_q;
  logic                      eoi2_q;

  always_comb begin
    sum_x  = SW'(p_xc_q) - SW'(p_ys_q);
    sum_y  = SW'(p_xs_q) + SW'(p_yc_q);
    bias_x = sum_x[SW-1] ? SW'({TRIG_FRAC_BITS{1'b1}}) : '0;
    bias_y = sum_y[SW-1] ? SW'({TRIG_FRAC_BITS{1'b1}}) : '0;
    adj_x  = sum_x + bias_x;
    adj_y  = sum_y + bias_y;
    sh_x   = adj_x >>> TRIG_FRAC_BITS;
    sh_y   = adj_y >>> TRIG_FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      tx_q     <= COORD_W'(sh_x) + cx1_q;
      ty_q     <= COORD_W'(sh_y) + cy1_q;
      color2_q <= color1_q;
      eoi2_q   <= eoi1_q;
    end
  end

  // output stage: clip against the area, far edges inclusive
  logic signed [CLIP_W-1:0] rel_x, rel_y;
  logic                     draw_d;
  logic                     draw_q, eoi_q;
  logic [SCR_W-1:0]         sx_q, sy_q;
  logic [COLOR_W-1:0]       color_q;

  always_comb begin
    rel_x  = CLIP_W'(tx_q) - CLIP_W'(cfg_i.area_x);
    rel_y  = CLIP_W'(ty_q) - CLIP_W'(cfg_i.area_y);
    draw_d = !rel_x[CLIP_W-1] && !rel_y[CLIP_W-1] &&
             (rel_x <= CLIP_W'(cfg_i.area_width)) &&
             (rel_y <= CLIP_W'(cfg_i.area_height));
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      draw_q  <= draw_d;
      sx_q    <= draw_d ? tx_q[SCR_W-1:0] : '0;
      sy_q    <= draw_d ? ty_q[SCR_W-1:0] : '0;
      color_q <= color2_q;
      eoi_q   <= eoi2_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign draw_o         = draw_q;
  assign screen_x_o     = sx_q;
  assign screen_y_o     = sy_q;
  assign color_o        = color_q;
  assign end_of_image_o = eoi_q;

endmodule

// ===== rtl/rotated_image_blitter.sv =====
// Rotated image blitter: takes RGB pixels in raster order, places the image in the
// target area by the alignment code, rotates each pixel about the image centre by
// the programmed whole-degree angle and clips it against the area (far edges
// inclusive). One result item per input item, in order. Sustained rate is one item
// per clock while the output is not stalled; a result passes through the queue, the
// multiply stage, the sum stage and the clip register, in that order. The front end
// computes placement and looks up sine and cosine from a quarter-wave table built
// at elaboration; a two-entry queue decouples it from the back end, whose four
// signed multipliers set the critical stage. Program the registers only while no
// item is in flight; the column and row counters are cleared by reset and at the
// end of each image, not by register writes.
module rotated_image_blitter import rib_pkg::*; #(
  parameter int MAX_IMAGE_DIM  = 1024,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CIDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CH_W-1:0]    red_i,
  input  logic [CH_W-1:0]    green_i,
  input  logic [CH_W-1:0]    blue_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               draw_o,
  output logic [SCR_W-1:0]   screen_x_o,
  output logic [SCR_W-1:0]   screen_y_o,
  output logic [COLOR_W-1:0] color_o,
  output logic               end_of_image_o
);

  localparam int DW   = $clog2(MAX_IMAGE_DIM + 1);
  localparam int DX_W = DW + 1;
  localparam int TW   = TRIG_FRAC_BITS + 2;

  typedef struct packed {
    logic signed [DX_W-1:0]    dx;
    logic signed [DX_W-1:0]    dy;
    logic signed [TW-1:0]      sin_v;
    logic signed [TW-1:0]      cos_v;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [COLOR_W-1:0]        color;
    logic                      eoi;
  } item_t;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.area_x           <= '0;
      cfg_q.area_y           <= '0;
      cfg_q.area_width       <= '0;
      cfg_q.area_height      <= '0;
      cfg_q.image_width      <= DIM_REG_W'(1);
      cfg_q.image_height     <= DIM_REG_W'(1);
      cfg_q.align_mode       <= ALIGN_W'(4);
      cfg_q.rotation_degrees <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_AREA_X:   cfg_q.area_x           <= cfg_data_i[AREA_W-1:0];
        REG_AREA_Y:   cfg_q.area_y           <= cfg_data_i[AREA_W-1:0];
        REG_AREA_W:   cfg_q.area_width       <= cfg_data_i[AREA_W-1:0];
        REG_AREA_H:   cfg_q.area_height      <= cfg_data_i[AREA_W-1:0];
        REG_IMG_W:    cfg_q.image_width      <= cfg_data_i[DIM_REG_W-1:0];
        REG_IMG_H:    cfg_q.image_height     <= cfg_data_i[DIM_REG_W-1:0];
        REG_ALIGN:    cfg_q.align_mode       <= cfg_data_i[ALIGN_W-1:0];
        REG_ROTATION: cfg_q.rotation_degrees <= cfg_data_i[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  logic  fq_valid, fq_ready, qb_valid, qb_ready;
  item_t fq_item, qb_item;

  rib_front #(
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .item_t        (item_t)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .item_valid_o (fq_valid),
    .item_ready_i (fq_ready),
    .item_o       (fq_item)
  );

  rib_queue #(
    .DEPTH (2),
    .item_t(item_t)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fq_valid),
    .in_ready_o (fq_ready),
    .in_item_i  (fq_item),
    .out_valid_o(qb_valid),
    .out_ready_i(qb_ready),
    .out_item_o (qb_item)
  );

  rib_back #(
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .item_t        (item_t)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (qb_valid),
    .item_ready_o  (qb_ready),
    .item_i        (qb_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .draw_o        (draw_o),
    .screen_x_o    (screen_x_o),
    .screen_y_o    (screen_y_o),
    .color_o       (color_o),
    .end_of_image_o(end_of_image_o)
  );

endmodule

// ===== rtl/rib_checker.sv =====
module rib_checker import rib_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               draw_o,
  input logic [SCR_W-1:0]   screen_x_o,
  input logic [SCR_W-1:0]   screen_y_o,
  input logic [COLOR_W-1:0] color_o,
  input logic               end_of_image_o
);

  // queue entries plus three back-end stages
  localparam logic [3:0] CAPACITY = 4'd5;

  logic       in_acc, out_acc;
  logic [3:0] pend_q;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(draw_o) &&
    $stable(screen_x_o) && $stable(screen_y_o) && $stable(color_o) &&
    $stable(end_of_image_o))
    else $error("result item changed while stalled");

  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !draw_o |-> screen_x_o == '0 && screen_y_o == '0)
    else $error("clipped item carries a coordinate");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result item without an accepted input item");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= CAPACITY)
    else $error("more items in flight than the pipeline holds");

endmodule

bind rotated_image_blitter rib_checker u_rib_checker (.*);

// ===== sim/rotated_image_blitter_tb.sv =====
module rotated_image_blitter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rib_pkg::*;

  localparam int FRAC        = 16;
  localparam int MAX_DIM     = 1024;
  localparam longint unsigned PI_FIXED30 = 64'd3373259426;
  localparam int ALIGN_CC    = 3 * ALIGN_CENTER + ALIGN_CENTER;
  localparam int ITEMS_TOTAL = 1050;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_REPORTS = 10;
  localparam int N_ROWS      = 47;

  typedef struct packed {
    logic               draw;
    logic [SCR_W-1:0]   sx;
    logic [SCR_W-1:0]   sy;
    logic [COLOR_W-1:0] color;
    logic               eoi;
  } blit_res_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_PIXEL, ROW_PIXEL_KNOWN} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    reg_idx_e           idx;
    logic [CFG_W-1:0]   val;
    logic [COLOR_W-1:0] rgb;
    blit_res_t          known;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CIDX_W-1:0]  cfg_idx = '0;
  logic [CFG_W-1:0]   cfg_val = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CH_W-1:0]    red = '0, green = '0, blue = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               draw;
  logic [SCR_W-1:0]   screen_x, screen_y;
  logic [COLOR_W-1:0] color;
  logic               eoi;

  rotated_image_blitter uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_idx),
    .cfg_data_i     (cfg_val),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .draw_o         (draw),
    .screen_x_o     (screen_x),
    .screen_y_o     (screen_y),
    .color_o        (color),
    .end_of_image_o (eoi)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  cfg_t      shadow;
  int        col_pos, row_pos;
  longint    sine_q16 [0:90];
  blit_res_t pending_pixels [$];

  // stimulus / bookkeeping
  bit        known_row = 1'b0;
  blit_res_t known_res = '0;
  bit        calm = 1'b0;
  int        hold_reqs = 0, hold_seen = 0, hold_left = 0;
  int        stall_cycles = 0;
  int        mismatches = 0, results_checked = 0, drawn = 0, images_closed = 0;
  int        pixels_sent = 0, rotated_pixels = 0, writes_done = 0;
  dir_row_t  directed_rows [N_ROWS];

  function automatic void build_sine_q16();
    longint unsigned ang, ang2, term, rnd, divisor;
    longint          acc;
    sine_q16[0]  = 0;
    sine_q16[90] = longint'(1) << FRAC;
    for (int k = 1; k < 90; k++) begin
      ang  = (64'(k) * PI_FIXED30) / 64'd180;
      ang2 = (ang * ang) >> 30;
      term = ang;
      acc  = 0;
      for (int n = 1; n < 40 && term != 0; n++) begin
        if (n % 2 == 1) acc += longint'(term);
        else acc -= longint'(term);
        divisor = 64'(2 * n * (2 * n + 1));
        term = ((term * ang2) >> 30) / divisor;
      end
      if (acc < 0) acc = 0;
      rnd = ((($unsigned(acc) << 1) >> (30 - FRAC)) + 64'd1) >> 1;
      if (rnd > (64'd1 << FRAC)) rnd = 64'd1 << FRAC;
      sine_q16[k] = longint'(rnd);
    end
  endfunction

  function automatic longint sine_deg(input int d);
    int a;
    a = d % 360;
    if (a <= DEG_QUARTER) return sine_q16[a];
    if (a <= DEG_HALF) return sine_q16[DEG_HALF - a];
    if (a <= DEG_3Q) return -sine_q16[a - DEG_HALF];
    return -sine_q16[DEG_FULL - a];
  endfunction

  function automatic longint drop_frac(input longint p);
    return (p < 0) ? -((-p) >>> FRAC) : (p >>> FRAC);
  endfunction

  function automatic longint dim_eff(input logic [DIM_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return longint'(v);
  endfunction

  function automatic longint place_off(input align_e sel, input longint span,
                                       input longint img);
    if (sel == ALIGN_CENTER) return (span - img) / 2;
    if (sel == ALIGN_END) return span - img;
    return 0;
  endfunction

  // place, rotate and clip one pixel, then step the raster position
  function automatic blit_res_t place_rotate_clip(input logic [COLOR_W-1:0] rgb);
    longint    iw, ih, left, top, px, py, tx, ty, cx, cy, s, c, dx, dy;
    longint    ax, ay;
    int        mode, deg;
    bit        last_col, last_row, vis;
    blit_res_t res;
    iw   = dim_eff(shadow.image_width);
    ih   = dim_eff(shadow.image_height);
    mode = (shadow.align_mode > ALIGN_MAX) ? ALIGN_CC : int'(shadow.align_mode);
    deg  = shadow.rotation_degrees % DEG_FULL;
    ax   = longint'(shadow.area_x);
    ay   = longint'(shadow.area_y);
    left = ax + place_off(align_e'(mode % 3), longint'(shadow.area_width), iw);
    top  = ay + place_off(align_e'(mode / 3), longint'(shadow.area_height), ih);
    px   = left + col_pos;
    py   = top + row_pos;
    tx   = px;
    ty   = py;
    if (deg != 0) begin
      rotated_pixels++;
      cx = left + iw / 2;
      cy = top + ih / 2;
      s  = sine_deg(deg);
      c  = sine_deg(deg + 90);
      dx = px - cx;
      dy = py - cy;
      tx = drop_frac(dx * c - dy * s) + cx;
      ty = drop_frac(dx * s + dy * c) + cy;
    end
    vis = (tx >= ax) && (ty >= ay) && (tx - ax <= longint'(shadow.area_width)) &&
          (ty - ay <= longint'(shadow.area_height));
    last_col  = col_pos >= iw - 1;
    last_row  = row_pos >= ih - 1;
    res.draw  = vis;
    res.sx    = vis ? SCR_W'(tx) : '0;
    res.sy    = vis ? SCR_W'(ty) : '0;
    res.color = rgb;
    res.eoi   = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  always @(posedge clk) begin : scoreboard
    blit_res_t want;
    blit_res_t got;
    if (!rst_n) begin
      shadow = '{area_x: '0, area_y: '0, area_width: '0, area_height: '0,
                 image_width: 11'd1, image_height: 11'd1,
                 align_mode: ALIGN_W'(ALIGN_CC), rotation_degrees: '0};
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_e'(cfg_idx))
          REG_AREA_X:   shadow.area_x = cfg_val;
          REG_AREA_Y:   shadow.area_y = cfg_val;
          REG_AREA_W:   shadow.area_width = cfg_val;
          REG_AREA_H:   shadow.area_height = cfg_val;
          REG_IMG_W:    shadow.image_width = cfg_val[DIM_REG_W-1:0];
          REG_IMG_H:    shadow.image_height = cfg_val[DIM_REG_W-1:0];
          REG_ALIGN:    shadow.align_mode = cfg_val[ALIGN_W-1:0];
          REG_ROTATION: shadow.rotation_degrees = cfg_val[DEG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = place_rotate_clip({red, green, blue});
        if (known_row) want = known_res;
        pending_pixels.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{draw: draw, sx: screen_x, sy: screen_y, color: color, eoi: eoi};
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected item draw=%0b x=%0d y=%0d color=%06h eoi=%0b",
                     $realtime, got.draw, got.sx, got.sy, got.color, got.eoi);
        end else begin
          want = pending_pixels.pop_front();
          results_checked++;
          if (want.draw) drawn++;
          if (want.eoi) images_closed++;
          if (got.draw !== want.draw || got.sx !== want.sx || got.sy !== want.sy ||
              got.color !== want.color || got.eoi !== want.eoi) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: item %0d got draw=%0b x=%0d y=%0d color=%06h eoi=%0b, %s",
                       $realtime, results_checked, got.draw, got.sx, got.sy, got.color,
                       got.eoi, $sformatf("want draw=%0b x=%0d y=%0d color=%06h eoi=%0b",
                       want.draw, want.sx, want.sy, want.color, want.eoi));
          end
        end
      end
      if (cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("no handshake for %0d cycles, %0d items outstanding",
                   STALL_LIMIT, pending_pixels.size());
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // output side: random stalls, calm stretch, and long hold-offs on request
  always @(negedge clk) begin : sink
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 35);
    end
  end

  task automatic send_pixel(input logic [COLOR_W-1:0] rgb);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    red      <= rgb[23:16];
    green    <= rgb[15:8];
    blue     <= rgb[7:0];
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input int val);
    cfg_we  <= 1'b1;
    cfg_idx <= idx;
    cfg_val <= CFG_W'(val);
    @(negedge clk);
    writes_done++;
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int rand_reg_value(input reg_idx_e idx);
    int p;
    p = $urandom_range(99);
    case (idx)
      REG_AREA_X, REG_AREA_Y:
        return (p < 80) ? $urandom_range(300) : $urandom_range(4095, 3800);
      REG_AREA_W, REG_AREA_H:
        if (p < 70) return $urandom_range(40);
        else if (p < 90) return $urandom_range(400, 41);
        else return $urandom_range(4095, 4000);
      REG_IMG_W, REG_IMG_H:
        if (p < 5) return 0;
        else if (p < 8) return $urandom_range(4095, 1000);
        else if (p < 20) return $urandom_range(40, 9);
        else return $urandom_range(8, 1);
      REG_ALIGN:
        return (p < 85) ? $urandom_range(8) : $urandom_range(15, 9);
      default:
        if (p < 25) return 0;
        else if (p < 55) return 90 * $urandom_range(4, 1);
        else return $urandom_range(511);
    endcase
  endfunction

  function automatic dir_row_t row_write(input reg_idx_e r, input int val);
    return '{kind: ROW_WRITE, idx: r, val: CFG_W'(val), rgb: '0, known: '0};
  endfunction

  function automatic dir_row_t row_pixel(input logic [COLOR_W-1:0] rgb);
    return '{kind: ROW_PIXEL, idx: REG_AREA_X, val: '0, rgb: rgb, known: '0};
  endfunction

  function automatic dir_row_t row_known(input logic [COLOR_W-1:0] rgb, input bit d,
                                         input int x, input int y, input bit e);
    return '{kind: ROW_PIXEL_KNOWN, idx: REG_AREA_X, val: '0, rgb: rgb,
             known: '{draw: d, sx: SCR_W'(x), sy: SCR_W'(y), color: rgb, eoi: e}};
  endfunction

  initial begin : stimulus
    dir_row_t row;
    bit       writing;
    longint   iw_e, ih_e, area, pos, head, burst;
    int       next_squeeze;
    build_sine_q16();
    directed_rows = '{
      // after reset: 1x1 image centred in an empty area at the origin
      row_known(24'hFFFFFF, 1'b1, 0, 0, 1'b1),
      row_known(24'h000000, 1'b1, 0, 0, 1'b1),
      // far corner, far edge inclusive
      row_write(REG_AREA_X, 'hFFF), row_write(REG_AREA_Y, 'hFFF),
      row_write(REG_AREA_W, 'hFFF), row_write(REG_AREA_H, 'hFFF),
      row_write(REG_ALIGN, 0),
      row_known(24'hA55A0F, 1'b1, 4095, 4095, 1'b1),
      // image wider than a zero area: end alignment pushes it out, bad code acts centred
      row_write(REG_AREA_W, 0), row_write(REG_AREA_H, 0),
      row_write(REG_ALIGN, 8),
      row_known(24'h5AA5F0, 1'b0, 0, 0, 1'b1),
      row_write(REG_ALIGN, 15),
      row_known(24'h123456, 1'b1, 4095, 4095, 1'b1),
      // 4x3 image, angle changed mid-image
      row_write(REG_AREA_X, 100), row_write(REG_AREA_Y, 50),
      row_write(REG_AREA_W, 20), row_write(REG_AREA_H, 10),
      row_write(REG_IMG_W, 4), row_write(REG_IMG_H, 3),
      row_write(REG_ALIGN, ALIGN_CC), row_write(REG_ROTATION, 90),
      row_pixel(24'h010203), row_pixel(24'h804020), row_pixel(24'h7F7F7F),
      row_write(REG_ROTATION, 180),
      row_pixel(24'hFF0000), row_pixel(24'h00FF00), row_pixel(24'h0000FF),
      row_write(REG_ROTATION, 270),
      row_pixel(24'hC0FFEE), row_pixel(24'h31415A),
      row_write(REG_ROTATION, 359),
      row_pixel(24'h55AA55), row_pixel(24'hAA55AA),
      // shrink below the current column: row and image end at once
      row_write(REG_IMG_W, 2),
      row_pixel(24'h0F0F0F),
      row_write(REG_ROTATION, 360),
      row_pixel(24'hF0F0F0),
      row_write(REG_ROTATION, 'h1FF),
      row_pixel(24'h123ABC), row_pixel(24'hFEDCBA),
      // zero and oversized dimensions
      row_write(REG_IMG_W, 0), row_write(REG_IMG_H, 'hFFF),
      row_pixel(24'h808080),
      row_write(REG_IMG_H, 0),
      row_pixel(24'h7E7E7E)
    };

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    writing = 1'b0;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (!writing) begin
          quiesce();
          writing = 1'b1;
        end
        write_reg(row.idx, int'(row.val));
      end else begin
        if (writing) begin
          end_writes();
          writing = 1'b0;
        end
        known_row = (row.kind == ROW_PIXEL_KNOWN);
        known_res = row.known;
        send_pixel(row.rgb);
      end
    end
    known_row = 1'b0;

    next_squeeze = 250;
    while (pixels_sent < ITEMS_TOTAL) begin
      calm = (pixels_sent >= 400 && pixels_sent < 560);
      quiesce();
      for (int r = 0; r < 8; r++)
        if ($urandom_range(1)) write_reg(reg_idx_e'(r), rand_reg_value(reg_idx_e'(r)));
      end_writes();
      iw_e = dim_eff(shadow.image_width);
      ih_e = dim_eff(shadow.image_height);
      area = iw_e * ih_e;
      if (area > 64) begin
        burst = $urandom_range(20, 1);
      end else if ($urandom_range(99) < 80) begin
        // finish any partial image, then whole images
        pos  = longint'(row_pos) * iw_e + col_pos;
        head = (row_pos < ih_e && col_pos < iw_e) ? (area - pos) % area : 0;
        burst = head + area * $urandom_range(3, 1);
      end else begin
        burst = $urandom_range(2 * area, 1);
      end
      if (burst > ITEMS_TOTAL - pixels_sent) burst = ITEMS_TOTAL - pixels_sent;
      if (pixels_sent >= next_squeeze) begin
        hold_reqs++;
        burst += 30;
        next_squeeze += 450;
      end
      repeat (burst) send_pixel(COLOR_W'($urandom));
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    $display("sent %0d pixels (%0d at a nonzero angle) over %0d register writes",
             pixels_sent, rotated_pixels, writes_done);
    $display("checked %0d results: %0d drawn, %0d image ends, %0d mismatches",
             results_checked, drawn, images_closed, mismatches);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rib_pkg.sv
rtl/rib_front.sv
rtl/rib_queue.sv
rtl/rib_back.sv
rtl/rotated_image_blitter.sv
rtl/rib_checker.sv
sim/rotated_image_blitter_tb.sv
